@@ hdl/plt_pkg.sv @@
// plt_pkg: sizes, command and status codes, cell control type and word
// conversion functions for the positional list table
// no dependencies
package plt_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 8;
	localparam int WORD_W     = 32;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int OUT_CNT_W  = 5;
	localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int MOD_STEP_W = $clog2(POS_W + 1);

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic [IDX_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] value;
	} cell_ctrl_t;

	// sign-extend or truncate a 32-bit input word to the stored width
	function automatic logic [DATA_WIDTH-1:0] to_data(input logic [WORD_W-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		for (int b = 0; b < DATA_WIDTH; b++) begin
			if (b < WORD_W)
				r[b] = v[b];
			else
				r[b] = v[WORD_W-1];
		end
		return r;
	endfunction

	// low 32 bits of a stored word, zero-filled when the word is narrower
	function automatic logic [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] d);
		logic [WORD_W-1:0] r;
		for (int b = 0; b < WORD_W; b++) begin
			r[b] = 1'b0;
			if (b < DATA_WIDTH)
				r[b] = d[b];
		end
		return r;
	endfunction

endpackage

@@ hdl/plt_cell.sv @@
// plt_cell: one entry of the table row, shifts toward either neighbor
// depends on plt_pkg
module plt_cell (
	input  logic                          clk,
	input  logic [plt_pkg::IDX_W-1:0]     idx,
	input  plt_pkg::cell_ctrl_t           ctrl,
	input  logic [plt_pkg::DATA_WIDTH-1:0] left_data,
	input  logic [plt_pkg::DATA_WIDTH-1:0] right_data,
	output logic [plt_pkg::DATA_WIDTH-1:0] data
);

	logic [plt_pkg::DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (idx == ctrl.pos)
				data_q <= ctrl.value;
			else if (idx > ctrl.pos)
				data_q <= left_data;
		end else if (ctrl.rem) begin
			if (idx >= ctrl.pos)
				data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

@@ hdl/plt_mod.sv @@
// plt_mod: bit-serial restoring remainder of the read position by the count
// depends on plt_pkg
module plt_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plt_pkg::POS_W-1:0]  dividend,
	input  logic [plt_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [plt_pkg::IDX_W-1:0]  rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [plt_pkg::MOD_STEP_W-1:0] step_q;
	logic [plt_pkg::POS_W-1:0]      dvd_q;
	logic [plt_pkg::CNT_W-1:0]      dsr_q;
	logic [plt_pkg::CNT_W-1:0]      rem_q;
	logic [plt_pkg::CNT_W:0]        trial;
	logic [plt_pkg::CNT_W:0]        diff;

	assign trial = {rem_q, dvd_q[plt_pkg::POS_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q &&
			          (step_q == plt_pkg::MOD_STEP_W'(plt_pkg::POS_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == plt_pkg::MOD_STEP_W'(plt_pkg::POS_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// remainder stays below the divisor, so it fits the cell index
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[plt_pkg::POS_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				rem_q <= diff[plt_pkg::CNT_W-1:0];
			else
				rem_q <= trial[plt_pkg::CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[plt_pkg::IDX_W-1:0];

endmodule

@@ hdl/positional_list_table_top.sv @@
// positional_list_table_top: ordered table held in a row of cells, with
// command sequencer, entry count, remainder unit and output register
// depends on plt_pkg, plt_cell, plt_mod
//
//  channel | direction | tdata                              | tuser
//  s_*     | in        | position[7:0], value[39:8]         | command[1:0]
//  m_*     | out       | read_value[31:0], entry_count[36:32] | status[1:0]
//
// insert, remove, clear and a read of an empty table go through accept, then
// execute; the cells at and above the position shift together in the execute cycle
// a read of a non-empty table goes through accept, remainder start,
// 8 one-bit-per-cycle remainder steps for the 8-bit position, a done cycle
// and the cell select cycle
// reset clears the count and the handshake state; cell contents are not reset
// a stalled output holds the sequencer in its last cycle until the result is taken
module positional_list_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], entry_count[36:32], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MOD  = 2'd2;
	localparam logic [1:0] S_RD   = 2'd3;

	logic [1:0]                     state_q;
	logic [plt_pkg::CMD_W-1:0]      cmd_q;
	logic [plt_pkg::POS_W-1:0]      pos_q;
	logic [plt_pkg::WORD_W-1:0]     val_q;
	logic [plt_pkg::CNT_W-1:0]      count_q;

	logic                           out_valid_q;
	logic [plt_pkg::STAT_W-1:0]     status_q;
	logic [plt_pkg::WORD_W-1:0]     rdval_q;
	logic [plt_pkg::OUT_CNT_W-1:0]  ocnt_q;

	logic                           out_free;
	logic                           out_load;
	logic                           in_acc;
	logic                           exec_out;
	logic                           exec_commit;
	logic                           mod_start;
	logic                           mod_done;
	logic [plt_pkg::IDX_W-1:0]      mod_rem;
	logic [plt_pkg::STAT_W-1:0]     exec_status;
	logic [plt_pkg::CNT_W-1:0]      next_count;
	logic                           do_ins;
	logic                           do_rem;
	plt_pkg::cell_ctrl_t            ctrl;
	logic [plt_pkg::DATA_WIDTH-1:0] cell_data [plt_pkg::CAPACITY];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// command decode against the current count
	always_comb begin
		exec_status = plt_pkg::ST_OK;
		next_count  = count_q;
		do_ins      = 1'b0;
		do_rem      = 1'b0;
		mod_start   = 1'b0;
		exec_out    = 1'b1;
		case (cmd_q)
			plt_pkg::CMD_INSERT: begin
				if (count_q == plt_pkg::CNT_W'(plt_pkg::CAPACITY))
					exec_status = plt_pkg::ST_FULL;
				else if (plt_pkg::CMP_W'(pos_q) > plt_pkg::CMP_W'(count_q))
					exec_status = plt_pkg::ST_RANGE;
				else begin
					do_ins     = 1'b1;
					next_count = count_q + 1'b1;
				end
			end
			plt_pkg::CMD_REMOVE: begin
				if (count_q == '0)
					exec_status = plt_pkg::ST_EMPTY;
				else if (plt_pkg::CMP_W'(pos_q) >= plt_pkg::CMP_W'(count_q))
					exec_status = plt_pkg::ST_RANGE;
				else begin
					do_rem     = 1'b1;
					next_count = count_q - 1'b1;
				end
			end
			plt_pkg::CMD_READ: begin
				if (count_q == '0)
					exec_status = plt_pkg::ST_EMPTY;
				else begin
					exec_out  = 1'b0;
					mod_start = (state_q == S_EXEC);
				end
			end
			plt_pkg::CMD_CLEAR: begin
				next_count = '0;
			end
			default: begin
				exec_status = plt_pkg::ST_OK;
			end
		endcase
	end

	assign exec_commit = (state_q == S_EXEC) && exec_out && out_free;
	assign out_load    = exec_commit || (state_q == S_RD && out_free);

	assign ctrl.ins   = exec_commit && do_ins;
	assign ctrl.rem   = exec_commit && do_rem;
	assign ctrl.pos   = pos_q[plt_pkg::IDX_W-1:0];
	assign ctrl.value = plt_pkg::to_data(val_q);

	for (genvar i = 0; i < plt_pkg::CAPACITY; i++) begin : g_cell
		logic [plt_pkg::DATA_WIDTH-1:0] left_d;
		logic [plt_pkg::DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_head
			assign left_d = ctrl.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == plt_pkg::CAPACITY - 1) begin : g_tail
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		plt_cell u_cell (
			.clk        (clk),
			.idx        (plt_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	plt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (pos_q),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (mod_start)
						state_q <= S_MOD;
					else if (exec_commit) begin
						count_q <= next_count;
						state_q <= S_IDLE;
					end
				end
				S_MOD: begin
					if (mod_done)
						state_q <= S_RD;
				end
				S_RD: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_tuser;
			pos_q <= s_tdata[7:0];
			val_q <= s_tdata[39:8];
		end
		if (exec_commit) begin
			status_q <= exec_status;
			rdval_q  <= '0;
			ocnt_q   <= plt_pkg::OUT_CNT_W'(next_count);
		end else if (state_q == S_RD && out_free) begin
			status_q <= plt_pkg::ST_OK;
			rdval_q  <= plt_pkg::to_word(cell_data[mod_rem]);
			ocnt_q   <= plt_pkg::OUT_CNT_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, ocnt_q, rdval_q};
	assign m_tuser  = status_q;

endmodule
